// ----- sv/hzbb_pkg.sv -----
// ----------------------------------------------------------------------------
// hzbb_pkg
// Shared types, register codes and reset values for the humidity zone
// on/off controller.
// ----------------------------------------------------------------------------
package hzbb_pkg;

    // Operating modes.
    localparam logic [2:0] MODE_DISABLED = 3'd0;
    localparam logic [2:0] MODE_OFF      = 3'd1;
    localparam logic [2:0] MODE_DEHUM    = 3'd2;
    localparam logic [2:0] MODE_HUM      = 3'd3;
    localparam logic [2:0] MODE_AUTO     = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MODE          = 3'd0;
    localparam logic [2:0] CFG_DEVICES       = 3'd1;
    localparam logic [2:0] CFG_TARGET_RH     = 3'd2;
    localparam logic [2:0] CFG_HYSTERESIS_RH = 3'd3;
    localparam logic [2:0] CFG_MOLD_RH       = 3'd4;
    localparam logic [2:0] CFG_MOLD_DURATION = 3'd5;
    localparam logic [2:0] CFG_MIN_OFF       = 3'd6;
    localparam logic [2:0] CFG_MIN_RUN       = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [2:0]  RST_MODE          = MODE_AUTO;
    localparam logic [1:0]  RST_DEVICES       = 2'd3;
    localparam logic [13:0] RST_TARGET_RH     = 14'd5000;
    localparam logic [10:0] RST_HYSTERESIS_RH = 11'd500;
    localparam logic [13:0] RST_MOLD_RH       = 14'd7000;
    localparam logic [31:0] RST_MOLD_DURATION = 32'd3600000;
    localparam logic [31:0] RST_MIN_OFF       = 32'd0;
    localparam logic [31:0] RST_MIN_RUN       = 32'd0;

    // Configuration register file contents.
    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  devices_present;
        logic [13:0] target_rh;
        logic [10:0] hysteresis_rh;
        logic [13:0] mold_rh;
        logic [31:0] mold_duration_ms;
        logic [31:0] min_off_ms;
        logic [31:0] min_run_ms;
    } cfg_t;

    // Per-sample control for one on/off machine.
    typedef struct packed {
        logic enable;     // machine runs this sample
        logic force_off;  // running bit is cleared this sample
        logic too_far;    // humidity is on the side that starts the device
        logic back_far;   // humidity is on the side that stops the device
    } mach_ctrl_t;

endpackage

// ----- sv/hzbb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hzbb_cfg_regs
// Configuration register file, written one word at a time by index.
// ----------------------------------------------------------------------------
module hzbb_cfg_regs
    import hzbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the write index and truncate the data to the register width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:          cfg_next.mode             = cfg_data[2:0];
                CFG_DEVICES:       cfg_next.devices_present  = cfg_data[1:0];
                CFG_TARGET_RH:     cfg_next.target_rh        = cfg_data[13:0];
                CFG_HYSTERESIS_RH: cfg_next.hysteresis_rh    = cfg_data[10:0];
                CFG_MOLD_RH:       cfg_next.mold_rh          = cfg_data[13:0];
                CFG_MOLD_DURATION: cfg_next.mold_duration_ms = cfg_data;
                CFG_MIN_OFF:       cfg_next.min_off_ms       = cfg_data;
                CFG_MIN_RUN:       cfg_next.min_run_ms       = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode             <= RST_MODE;
            cfg_reg.devices_present  <= RST_DEVICES;
            cfg_reg.target_rh        <= RST_TARGET_RH;
            cfg_reg.hysteresis_rh    <= RST_HYSTERESIS_RH;
            cfg_reg.mold_rh          <= RST_MOLD_RH;
            cfg_reg.mold_duration_ms <= RST_MOLD_DURATION;
            cfg_reg.min_off_ms       <= RST_MIN_OFF;
            cfg_reg.min_run_ms       <= RST_MIN_RUN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/hzbb_mold.sv -----
// ----------------------------------------------------------------------------
// hzbb_mold
// Mold-risk timer: raises the risk once humidity has stayed above the mold
// threshold for the configured duration.
// ----------------------------------------------------------------------------
module hzbb_mold
    import hzbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        run,
    input  logic [13:0] humidity,
    input  logic [31:0] now_ms,
    input  logic [13:0] mold_rh,
    input  logic [31:0] mold_duration_ms,
    output logic        mold_active_next,
    output logic        alarm_new
);

    logic        high_timing_reg;
    logic        high_timing_next;
    logic [31:0] high_start_reg;
    logic [31:0] high_start_next;
    logic        mold_active_reg;
    logic [31:0] elapsed;

    // Time above the threshold, counting this sample as the start if needed.
    assign elapsed = now_ms - (high_timing_reg ? high_start_reg : now_ms);

    always_comb
    begin
        high_timing_next = high_timing_reg;
        high_start_next  = high_start_reg;
        mold_active_next = mold_active_reg;
        alarm_new        = 1'b0;
        if (run)
        begin
            if (humidity > mold_rh)
            begin
                if (!high_timing_reg)
                begin
                    high_timing_next = 1'b1;
                    high_start_next  = now_ms;
                end
                if (elapsed >= mold_duration_ms && !mold_active_reg)
                begin
                    mold_active_next = 1'b1;
                    alarm_new        = 1'b1;
                end
            end
            else
            begin
                high_timing_next = 1'b0;
                high_start_next  = '0;
                mold_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_timing_reg <= 1'b0;
            high_start_reg  <= '0;
            mold_active_reg <= 1'b0;
        end
        else if (step)
        begin
            high_timing_reg <= high_timing_next;
            high_start_reg  <= high_start_next;
            mold_active_reg <= mold_active_next;
        end
    end

endmodule

// ----- sv/hzbb_machine.sv -----
// ----------------------------------------------------------------------------
// hzbb_machine
// One on/off device machine with minimum off time, minimum run time and a
// saturating runtime accumulator. Start and stop times are shared and pass
// through so two machines can be chained.
// ----------------------------------------------------------------------------
module hzbb_machine
    import hzbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  mach_ctrl_t  ctrl,
    input  logic [31:0] now_ms,
    input  logic [31:0] min_off_ms,
    input  logic [31:0] min_run_ms,
    input  logic [31:0] start_in,
    input  logic [31:0] stop_in,
    output logic [31:0] start_out,
    output logic [31:0] stop_out,
    output logic        running_next,
    output logic [31:0] runtime_next
);

    logic        running_reg;
    logic [31:0] account_reg;
    logic [31:0] account_next;
    logic [31:0] runtime_reg;
    logic [32:0] runtime_sum;

    // Saturating runtime update.
    assign runtime_sum = {1'b0, runtime_reg} + {1'b0, now_ms - account_reg};

    always_comb
    begin
        running_next = running_reg;
        account_next = account_reg;
        runtime_next = runtime_reg;
        start_out    = start_in;
        stop_out     = stop_in;
        if (ctrl.force_off)
        begin
            running_next = 1'b0;
        end
        else if (ctrl.enable)
        begin
            if (!running_reg)
            begin
                if (ctrl.too_far && (now_ms - stop_in) >= min_off_ms)
                begin
                    running_next = 1'b1;
                    start_out    = now_ms;
                    account_next = now_ms;
                end
            end
            else
            begin
                runtime_next = runtime_sum[32] ? '1 : runtime_sum[31:0];
                account_next = now_ms;
                if (ctrl.back_far && (now_ms - start_in) >= min_run_ms)
                begin
                    running_next = 1'b0;
                    stop_out     = now_ms;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            account_reg <= '0;
            runtime_reg <= '0;
        end
        else if (step)
        begin
            running_reg <= running_next;
            account_reg <= account_next;
            runtime_reg <= runtime_next;
        end
    end

endmodule

// ----- sv/humidity_zone_bang_bang_controller.sv -----
// ----------------------------------------------------------------------------
// humidity_zone_bang_bang_controller
// Humidity zone on/off controller: dehumidifier and humidifier hysteresis
// machines, a mold-risk timer and saturating runtime counters.
//
//   Channel  | Handshake                | Word
//   ---------+--------------------------+------------------------------------
//   input    | in_valid / in_ready      | humidity, sensor_valid, now_ms
//   result   | out_valid / out_ready    | drives, mold flags, error, runtimes
//   config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One word is taken per cycle unless the result register is held; its result
// passes through the input register, then the result register, and all state
// updates on the edge that loads the result register. Reset clears all control
// state and loads the register defaults; no clearing pass is needed. When the
// result register is held by out_ready low, the input register holds too, and
// in_ready drops only once both are full. Config writes are taken every cycle.
// ----------------------------------------------------------------------------
module humidity_zone_bang_bang_controller
    import hzbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [13:0] humidity,
    input  logic        sensor_valid,
    input  logic [31:0] now_ms,
    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        dehumidifier_on,
    output logic        humidifier_on,
    output logic        mold_warning,
    output logic        mold_alarm_new,
    output logic        sensor_error,
    output logic [31:0] dehum_runtime_ms,
    output logic [31:0] hum_runtime_ms,
    // Configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t        cfg;

    logic        in_valid_reg;
    logic [13:0] hum_reg;
    logic        sv_reg;
    logic [31:0] now_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        step;

    logic        mode_ok;
    logic        run;
    logic        high;
    logic        low;
    logic [14:0] upper;
    logic [14:0] hum_plus_hyst;

    mach_ctrl_t  dehum_ctrl;
    mach_ctrl_t  hum_ctrl;

    logic [31:0] start_reg;
    logic [31:0] stop_reg;
    logic [31:0] start_mid;
    logic [31:0] stop_mid;
    logic [31:0] start_next;
    logic [31:0] stop_next;

    logic        dehum_running_next;
    logic        hum_running_next;
    logic [31:0] dehum_runtime_next;
    logic [31:0] hum_runtime_next;
    logic        mold_active_next;
    logic        alarm_new;

    logic        error_reg;
    logic        error_next;

    logic        dehum_on_reg;
    logic        hum_on_reg;
    logic        mold_warn_reg;
    logic        alarm_reg;
    logic        err_out_reg;
    logic [31:0] dehum_rt_reg;
    logic [31:0] hum_rt_reg;

    // Configuration registers.
    hzbb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the work stage fires when the result register can load.
    assign step           = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || step;
    assign out_valid_next = step || (out_valid_reg && !out_ready);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hum_reg <= humidity;
            sv_reg  <= sensor_valid;
            now_reg <= now_ms;
        end
    end

    // Mode decode.
    always_comb
    begin
        mode_ok = cfg.mode inside {[MODE_OFF:MODE_AUTO]};
    end

    assign run = mode_ok && sv_reg;

    // Band compares; the lower edge is tested as humidity + hyst < target so
    // a band that dips below zero never reads as low.
    assign upper         = {1'b0, cfg.target_rh} + {4'b0, cfg.hysteresis_rh};
    assign hum_plus_hyst = {1'b0, hum_reg} + {4'b0, cfg.hysteresis_rh};
    assign high          = {1'b0, hum_reg} > upper;
    assign low           = hum_plus_hyst < {1'b0, cfg.target_rh};

    // Machine controls.
    always_comb
    begin
        dehum_ctrl.force_off = !mode_ok || (sv_reg && cfg.mode == MODE_OFF);
        dehum_ctrl.enable    = run && cfg.devices_present[0]
                               && (cfg.mode == MODE_DEHUM || cfg.mode == MODE_AUTO);
        dehum_ctrl.too_far   = high;
        dehum_ctrl.back_far  = low;
        hum_ctrl.force_off   = dehum_ctrl.force_off;
        hum_ctrl.enable      = run && cfg.devices_present[1]
                               && (cfg.mode == MODE_HUM || cfg.mode == MODE_AUTO);
        hum_ctrl.too_far     = low;
        hum_ctrl.back_far    = high;
    end

    // Mold-risk timer.
    hzbb_mold u_mold (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .run              (run),
        .humidity         (hum_reg),
        .now_ms           (now_reg),
        .mold_rh          (cfg.mold_rh),
        .mold_duration_ms (cfg.mold_duration_ms),
        .mold_active_next (mold_active_next),
        .alarm_new        (alarm_new)
    );

    // Dehumidifier runs first; the humidifier sees its shared time updates.
    hzbb_machine u_dehum (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .ctrl         (dehum_ctrl),
        .now_ms       (now_reg),
        .min_off_ms   (cfg.min_off_ms),
        .min_run_ms   (cfg.min_run_ms),
        .start_in     (start_reg),
        .stop_in      (stop_reg),
        .start_out    (start_mid),
        .stop_out     (stop_mid),
        .running_next (dehum_running_next),
        .runtime_next (dehum_runtime_next)
    );

    hzbb_machine u_hum (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .ctrl         (hum_ctrl),
        .now_ms       (now_reg),
        .min_off_ms   (cfg.min_off_ms),
        .min_run_ms   (cfg.min_run_ms),
        .start_in     (start_mid),
        .stop_in      (stop_mid),
        .start_out    (start_next),
        .stop_out     (stop_next),
        .running_next (hum_running_next),
        .runtime_next (hum_runtime_next)
    );

    // Error flag: set by an invalid sample, cleared by a valid one; held while disabled.
    always_comb
    begin
        error_next = error_reg;
        if (mode_ok)
        begin
            error_next = !sv_reg;
        end
    end

    // Shared start/stop times and the error flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            stop_reg  <= '0;
            error_reg <= 1'b0;
        end
        else if (step)
        begin
            start_reg <= start_next;
            stop_reg  <= stop_next;
            error_reg <= error_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            dehum_on_reg  <= dehum_running_next && cfg.devices_present[0];
            hum_on_reg    <= hum_running_next && cfg.devices_present[1];
            mold_warn_reg <= mold_active_next;
            alarm_reg     <= alarm_new;
            err_out_reg   <= error_next;
            dehum_rt_reg  <= dehum_runtime_next;
            hum_rt_reg    <= hum_runtime_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign dehumidifier_on  = dehum_on_reg;
    assign humidifier_on    = hum_on_reg;
    assign mold_warning     = mold_warn_reg;
    assign mold_alarm_new   = alarm_reg;
    assign sensor_error     = err_out_reg;
    assign dehum_runtime_ms = dehum_rt_reg;
    assign hum_runtime_ms   = hum_rt_reg;

endmodule
